>>> src/spi_master_frame_transmitter_assert.svh
// assertion macros for the spi master frame transmitter
`ifndef SPI_MASTER_FRAME_TRANSMITTER_ASSERT_SVH
`define SPI_MASTER_FRAME_TRANSMITTER_ASSERT_SVH

// same-cycle implication, checked out of reset
`define SMFT_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define SMFT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/spimft_pkg.sv
// shared constants and types for the spi master frame transmitter
package spimft_pkg;

    // configuration register index, taken from paddr[3:2]
    localparam logic [1:0] REG_SPI_MODE     = 2'd0;
    localparam logic [1:0] REG_FRAME_LEN    = 2'd1;
    localparam logic [1:0] REG_HALF_PERIOD  = 2'd2;
    localparam logic [1:0] REG_SELECT_LEVEL = 2'd3;

    // register reset values
    localparam logic [1:0] SPI_MODE_RST     = 2'd0;
    localparam logic [4:0] FRAME_LEN_RST    = 5'd8;
    localparam logic [7:0] HALF_PERIOD_RST  = 8'd1;
    localparam logic       SELECT_LEVEL_RST = 1'b0;

    // request codes
    localparam logic REQ_TICK  = 1'b0;
    localparam logic REQ_START = 1'b1;

    // one result word
    typedef struct packed {
        logic sclk_level;
        logic mosi_level;
        logic select_level;
        logic busy_res;
        logic rejected;
    } result_t;

endpackage

>>> src/spi_master_frame_transmitter.sv
// transmit-only spi master that steps one request word per cycle unless the result channel stalls
//
// Usage: the s_ channel carries request words, either a tick (advance the
// serial timing by one tick) or a start (load a frame built from
// (prefix_word << frame_len) + payload_word and begin shifting it out msb
// first). Every accepted word yields exactly one result word on the m_
// channel with the pin levels after that word, the busy flag and a flag
// for a start that was dropped because a frame was still in progress.
// The result of a word accepted at an edge is valid right after it. One word
// is taken per cycle while the result channel is not stalled; the next state
// and pin levels come from a few flags, a shift/add and the tick counter
// between the state registers and the result register.
// If the receiver stalls, the result register holds its word and s_ready
// drops until it is taken; s_ready stays high while the result is consumed.
// Reset (aresetn low at a clock edge) clears the frame state, sets the pins
// to clock low, data low, select high, and loads the register defaults.
// The apb port configures mode, frame length, half period and select level;
// write it only while no request is in flight.
`include "spi_master_frame_transmitter_assert.svh"

module spi_master_frame_transmitter #(
    parameter int FRAME_WIDTH = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    // apb configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // request channel
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_req_type,
    input  logic [31:0] s_prefix_word,
    input  logic [31:0] s_payload_word,
    // result channel
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_sclk_level,
    output logic        m_mosi_level,
    output logic        m_select_level,
    output logic        m_busy_res,
    output logic        m_rejected
);

    // configuration registers
    logic [1:0] spi_mode_reg;
    logic [4:0] frame_len_reg;
    logic [7:0] half_period_reg;
    logic       select_active_reg;

    // frame state
    logic [FRAME_WIDTH-1:0] frame_reg, frame_next;
    logic [4:0] bit_index_reg, bit_index_next;
    logic       second_half_reg, second_half_next;
    logic [7:0] tick_count_reg, tick_count_next;
    logic       active_reg, active_next;
    logic       clock_pin_reg, clock_pin_next;
    logic       data_pin_reg, data_pin_next;
    logic       select_pin_reg, select_pin_next;
    logic       rejected_next;

    // result register
    logic                 m_valid_reg;
    spimft_pkg::result_t  result_reg;

    // helpers
    logic        cpol, cpha;
    logic [7:0]  half_period;
    logic [7:0]  tick_inc;
    logic [31:0] frame_sum;
    logic [31:0] frame_ext;
    logic        in_accept;
    logic        cfg_write;

    assign cpol        = spi_mode_reg[1];
    assign cpha        = spi_mode_reg[0];
    assign half_period = (half_period_reg == 8'd0) ? 8'd1 : half_period_reg;
    assign tick_inc    = tick_count_reg + 8'd1;
    assign frame_sum   = (s_prefix_word << frame_len_reg) + s_payload_word;

    assign s_ready   = !m_valid_reg || m_ready;
    assign in_accept = s_valid && s_ready;
    assign cfg_write = psel && penable && pwrite && pready;
    assign pready    = 1'b1;

    // apb read mux
    always_comb begin
        prdata = 32'd0;
        unique case (paddr[3:2])
            spimft_pkg::REG_SPI_MODE:     prdata = 32'(spi_mode_reg);
            spimft_pkg::REG_FRAME_LEN:    prdata = 32'(frame_len_reg);
            spimft_pkg::REG_HALF_PERIOD:  prdata = 32'(half_period_reg);
            spimft_pkg::REG_SELECT_LEVEL: prdata = 32'(select_active_reg);
            default:                      prdata = 32'd0;
        endcase
    end

    // configuration register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            spi_mode_reg      <= spimft_pkg::SPI_MODE_RST;
            frame_len_reg     <= spimft_pkg::FRAME_LEN_RST;
            half_period_reg   <= spimft_pkg::HALF_PERIOD_RST;
            select_active_reg <= spimft_pkg::SELECT_LEVEL_RST;
        end else if (cfg_write) begin
            unique case (paddr[3:2])
                spimft_pkg::REG_SPI_MODE:     spi_mode_reg      <= pwdata[1:0];
                spimft_pkg::REG_FRAME_LEN:    frame_len_reg     <= pwdata[4:0];
                spimft_pkg::REG_HALF_PERIOD:  half_period_reg   <= pwdata[7:0];
                spimft_pkg::REG_SELECT_LEVEL: select_active_reg <= pwdata[0];
                default: ;
            endcase
        end
    end

    // next frame state for one request word
    always_comb begin
        frame_next       = frame_reg;
        bit_index_next   = bit_index_reg;
        second_half_next = second_half_reg;
        tick_count_next  = tick_count_reg;
        active_next      = active_reg;
        clock_pin_next   = clock_pin_reg;
        data_pin_next    = data_pin_reg;
        select_pin_next  = select_pin_reg;
        rejected_next    = 1'b0;

        if (s_req_type == spimft_pkg::REQ_START) begin
            if (active_reg) begin
                rejected_next = 1'b1;
            end else begin
                // load frame, clock to idle (to the active level when cpha is set), select active, enter top bit
                frame_next       = frame_sum[FRAME_WIDTH-1:0];
                select_pin_next  = select_active_reg;
                bit_index_next   = frame_len_reg;
                active_next      = 1'b1;
                second_half_next = 1'b0;
                tick_count_next  = 8'd0;
                clock_pin_next   = cpha ? !cpol : cpol;
            end
        end else if (active_reg) begin
            if (tick_inc < half_period) begin
                tick_count_next = tick_inc;
            end else begin
                tick_count_next = 8'd0;
                if (!second_half_reg) begin
                    // end of first half
                    clock_pin_next   = cpha ? cpol : !cpol;
                    second_half_next = 1'b1;
                end else begin
                    // end of second half
                    if (!cpha) begin
                        clock_pin_next = cpol;
                    end
                    if (bit_index_reg == 5'd0) begin
                        active_next      = 1'b0;
                        second_half_next = 1'b0;
                    end else begin
                        bit_index_next   = bit_index_reg - 5'd1;
                        second_half_next = 1'b0;
                        if (cpha) begin
                            clock_pin_next = !cpol;
                        end
                    end
                end
            end
        end

        // data pin takes the current bit whenever a bit is entered
        frame_ext = 32'(frame_next);
        if ((s_req_type == spimft_pkg::REQ_START && !active_reg) ||
            (s_req_type == spimft_pkg::REQ_TICK && active_reg && active_next &&
             bit_index_next != bit_index_reg)) begin
            data_pin_next = frame_ext[bit_index_next];
        end
    end

    // frame state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bit_index_reg   <= 5'd0;
            second_half_reg <= 1'b0;
            tick_count_reg  <= 8'd0;
            active_reg      <= 1'b0;
            clock_pin_reg   <= 1'b0;
            data_pin_reg    <= 1'b0;
            select_pin_reg  <= 1'b1;
            frame_reg       <= '0;
        end else if (in_accept) begin
            frame_reg       <= frame_next;
            bit_index_reg   <= bit_index_next;
            second_half_reg <= second_half_next;
            tick_count_reg  <= tick_count_next;
            active_reg      <= active_next;
            clock_pin_reg   <= clock_pin_next;
            data_pin_reg    <= data_pin_next;
            select_pin_reg  <= select_pin_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (in_accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            result_reg.sclk_level   <= clock_pin_next;
            result_reg.mosi_level   <= data_pin_next;
            result_reg.select_level <= select_pin_next;
            result_reg.busy_res     <= active_next;
            result_reg.rejected     <= rejected_next;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_sclk_level   = result_reg.sclk_level;
    assign m_mosi_level   = result_reg.mosi_level;
    assign m_select_level = result_reg.select_level;
    assign m_busy_res     = result_reg.busy_res;
    assign m_rejected     = result_reg.rejected;

    // checks
    `SMFT_ASSERT_NEXT(a_accept_gives_result, s_valid && s_ready, m_valid,
        "accepted word produced no result")
    `SMFT_ASSERT_SAME(a_reject_only_busy, m_valid && m_rejected, m_busy_res,
        "rejected start reported while idle")
    `SMFT_ASSERT_SAME(a_idle_timing_clear, !active_reg,
        !second_half_reg && tick_count_reg == 8'd0,
        "bit timing left dirty while idle")

endmodule
